// ===== src/deadf_pkg.sv =====
// Shared types and constants for the dual echo arrival difference block.
// Used by deadf_div and dual_echo_arrival_difference; depends on nothing.
package deadf_pkg;

  // Field widths fixed by the interface
  localparam int MAG_BITS      = 16;                  // max_difference / deadzone width
  localparam int SIL_CFG_BITS  = 24;                  // silence_ticks register width
  localparam int CFG_DATA_BITS = 24;                  // widest register
  localparam int CFG_IDX_BITS  = 2;
  localparam int Q_BITS        = 15;                  // quotient bits, result <= 32767
  localparam int DIVIDEND_BITS = MAG_BITS + Q_BITS;   // mag * 32767 fits in 31 bits
  localparam int DIV_CNT_BITS  = 4;                   // counts Q_BITS steps

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIFF = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE  = 2'd2;

  // Register reset values
  localparam logic [MAG_BITS-1:0]     MAX_DIFF_RESET = 16'd1000;
  localparam logic [MAG_BITS-1:0]     DEADZONE_RESET = 16'd0;
  localparam logic [SIL_CFG_BITS-1:0] SILENCE_RESET  = 24'd100000;

  // Status codes
  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_DEADZONE = 2'd1;
  localparam logic [1:0] STATUS_REPORTED = 2'd2;

  // Input word: one microsecond tick
  typedef struct packed {
    logic left_fall;
    logic right_fall;
    logic take;
  } in_word_t;

  // Output word: one per tick
  typedef struct packed {
    logic               available;
    logic [1:0]         status;
    logic signed [15:0] scaled_difference;
  } out_word_t;

  // Divider handshake
  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [MAG_BITS-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/deadf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Q15 scaling.
// Depends on deadf_pkg. Quotient is known to fit in Q_BITS bits.
module deadf_div (
  input  logic                clk,
  input  logic                rst,
  input  deadf_pkg::div_req_t req,
  output deadf_pkg::div_rsp_t rsp
);
  import deadf_pkg::*;

  logic [MAG_BITS-1:0]     rem;
  logic [Q_BITS-1:0]       qs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;
  logic [MAG_BITS:0]       shifted;
  logic [MAG_BITS:0]       trial;

  // one trial subtract per step
  assign shifted = {rem, qs[Q_BITS-1]};
  assign trial   = shifted - {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // high part is already below the divisor, so Q_BITS steps suffice
        rem  <= req.dividend[DIVIDEND_BITS-1:Q_BITS];
        qs   <= req.dividend[Q_BITS-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[MAG_BITS]) begin
          rem <= trial[MAG_BITS-1:0];
          qs  <= {qs[Q_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[MAG_BITS-1:0];
          qs  <= {qs[Q_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = qs;

endmodule

// ===== src/dual_echo_arrival_difference.sv =====
// Top level of the dual echo arrival difference block: sequencer and state.
// Depends on deadf_pkg and deadf_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one word per
//   microsecond tick: left and right falling-edge flags and a take request.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   word per input word: available, status and the Q15 scaled difference.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the block is idle; the user must keep to that, as the block does not
//   enforce it. Index 0 max_difference, 1 deadzone, 2 silence_ticks.
// Timing:
//   A word that does not take a ready pair goes from IDLE, where it is
//   accepted, to OUT, where its result word is offered. A take of a ready
//   pair passes DIFF, CLAMP and CHECK; a deadzone result goes on to OUT. One
//   that reports loads the restoring divider and runs it for 15 steps in DIV;
//   its result word is offered in OUT once the divider is done. in_stall is
//   high from accept until the result word has been taken.
// Reset:
//   rst clears the tick counter, stamps, capture flags and silence timer and
//   loads the register defaults. While out_stall is high the result word is
//   held unchanged and no new input word is accepted.
module dual_echo_arrival_difference #(
  parameter int STAMP_BITS   = 32,
  parameter int SILENCE_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  deadf_pkg::in_word_t                        in_data,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output deadf_pkg::out_word_t                       out_data,
  input  logic                                       cfg_write,
  input  logic [deadf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [deadf_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import deadf_pkg::*;

  typedef enum logic [2:0] {IDLE, DIFF, CLAMP, CHECK, DIV, OUT} state_t;

  state_t state;

  // configuration registers
  logic [MAG_BITS-1:0]     max_difference;
  logic [MAG_BITS-1:0]     deadzone;
  logic [SIL_CFG_BITS-1:0] silence_ticks;

  // block state
  logic [STAMP_BITS-1:0]   time_counter;
  logic [STAMP_BITS-1:0]   left_stamp;
  logic [STAMP_BITS-1:0]   right_stamp;
  logic                    left_taken;
  logic                    right_taken;
  logic                    pair_ready;
  logic                    silent;
  logic [SILENCE_BITS-1:0] silence_left;

  // take datapath
  logic                    neg;
  logic [STAMP_BITS-1:0]   mag_full;
  logic [MAG_BITS-1:0]     mag_c;
  logic [1:0]              status;
  logic signed [15:0]      scaled;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    accept;
  logic [SILENCE_BITS-1:0] sil_dec;
  logic                    left_cap;
  logic                    right_cap;
  logic                    left_taken_mid;
  logic                    pr_mid;
  logic                    pr_after;
  logic [STAMP_BITS-1:0]   diff;
  logic [15:0]             q_ext;

  assign accept = in_valid && !in_stall;

  // silence countdown for this tick
  assign sil_dec = (silence_left != '0) ? silence_left - 1'b1 : silence_left;

  // edge capture, left then right
  assign left_cap       = in_data.left_fall && !pair_ready && !left_taken;
  assign left_taken_mid = left_taken || left_cap;
  assign pr_mid         = pair_ready || (left_cap && right_taken);
  assign right_cap      = in_data.right_fall && !pr_mid && !right_taken;
  assign pr_after       = pr_mid || (right_cap && left_taken_mid);

  assign diff  = left_stamp - right_stamp;
  assign q_ext = {1'b0, div_rsp.quotient};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_difference <= MAX_DIFF_RESET;
      deadzone       <= DEADZONE_RESET;
      silence_ticks  <= SILENCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_DIFF: max_difference <= cfg_data[MAG_BITS-1:0];
        REG_DEADZONE: deadzone       <= cfg_data[MAG_BITS-1:0];
        REG_SILENCE:  silence_ticks  <= cfg_data[SIL_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      time_counter  <= '0;
      left_stamp    <= '0;
      right_stamp   <= '0;
      left_taken    <= 1'b0;
      right_taken   <= 1'b0;
      pair_ready    <= 1'b0;
      silent        <= 1'b0;
      silence_left  <= '0;
      div_req.start <= 1'b0;
      status        <= STATUS_NONE;
      scaled        <= '0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            time_counter <= time_counter + 1'b1;
            if (silent) begin
              silence_left <= sil_dec;
              silent       <= (sil_dec != '0);
            end
            if (left_cap)  left_stamp  <= time_counter;
            if (right_cap) right_stamp <= time_counter;
            if (in_data.take && pr_after) begin
              left_taken  <= 1'b0;
              right_taken <= 1'b0;
              pair_ready  <= 1'b0;
              state       <= DIFF;
            end else begin
              left_taken  <= left_taken_mid;
              right_taken <= right_taken || right_cap;
              pair_ready  <= pr_after;
              status      <= STATUS_NONE;
              scaled      <= '0;
              state       <= OUT;
            end
          end
        end
        DIFF: begin
          // magnitude of the wrapped signed difference
          neg      <= diff[STAMP_BITS-1];
          mag_full <= diff[STAMP_BITS-1] ? STAMP_BITS'(0) - diff : diff;
          state    <= CLAMP;
        end
        CLAMP: begin
          mag_c <= (mag_full > STAMP_BITS'(max_difference)) ? max_difference
                                                             : mag_full[MAG_BITS-1:0];
          state <= CHECK;
        end
        CHECK: begin
          if (mag_c <= deadzone) begin
            status <= STATUS_DEADZONE;
            scaled <= '0;
            state  <= OUT;
          end else begin
            // mag * 32767 as a shift and subtract
            silent           <= 1'b1;
            silence_left     <= SILENCE_BITS'(silence_ticks);
            div_req.dividend <= {mag_c, {Q_BITS{1'b0}}} - DIVIDEND_BITS'(mag_c);
            div_req.divisor  <= max_difference;
            div_req.start    <= 1'b1;
            state            <= DIV;
          end
        end
        DIV: begin
          if (div_rsp.done) begin
            scaled <= neg ? -$signed(q_ext) : $signed(q_ext);
            status <= STATUS_REPORTED;
            state  <= OUT;
          end
        end
        OUT: begin
          if (!out_stall) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  deadf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ports
  assign in_stall                   = (state != IDLE);
  assign out_valid                  = (state == OUT);
  assign out_data.available         = pair_ready && !silent;
  assign out_data.status            = status;
  assign out_data.scaled_difference = scaled;

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input accepted while a result word is pending");

  a_zero_unless_reported: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_REPORTED) |-> (scaled == '0))
    else $error("nonzero difference without a report");

  a_report_silences: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_REPORTED) |-> (silent && !out_data.available))
    else $error("report without silence");

  a_pair_flags: assert property (@(posedge clk) disable iff (rst)
    pair_ready |-> (left_taken && right_taken))
    else $error("pair locked without both stamps");

endmodule

// ===== dv/dual_echo_arrival_difference_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dual_echo_arrival_difference: echo pairs, takes and
// register settings driven under random idling; every output word is checked
// against a tick-accurate predictor. Depends on deadf_pkg and the block's RTL.
module dual_echo_arrival_difference_tb;
  import deadf_pkg::*;

  localparam int          DRAIN_CYCLES = 40;
  localparam int          LONG_HOLD    = 300;
  localparam longint      TIMEOUT_NS   = 64'd20_000_000;
  localparam logic [47:0] Q15_FULL     = 48'd32767;

  // Clock, reset and block ports
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_word_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_word_t                out_data;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_MAX_DIFF;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // Predictor registers and state, at reset values
  logic [15:0] full_scale = MAX_DIFF_RESET;
  logic [15:0] dead_band  = DEADZONE_RESET;
  logic [23:0] mute_len   = SILENCE_RESET;
  logic [31:0] tick       = '0;
  logic [31:0] l_stamp    = '0;
  logic [31:0] r_stamp    = '0;
  logic        l_seen     = 1'b0;
  logic        r_seen     = 1'b0;
  logic        locked     = 1'b0;
  logic        muted      = 1'b0;
  logic [23:0] mute_left  = '0;

  // Expected output words, oldest first
  out_word_t tick_results_q[$];

  int errors       = 0;
  int words_sent   = 0;
  int echo_span    = 8;
  int tx_idle_odds = 6;
  int rx_idle_odds = 6;
  bit idle_off     = 1'b0;
  bit hold_req     = 1'b0;

  dual_echo_arrival_difference DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One tick of the arrival logic: silence, left edge, right edge, take, output
  function automatic out_word_t predict_tick(input in_word_t w);
    out_word_t   r;
    logic [31:0] d;
    logic [32:0] mag;
    logic [47:0] q;
    logic        neg;
    r = '0;
    if (muted) begin
      if (mute_left != 0) mute_left = mute_left - 1'b1;
      if (mute_left == 0) muted = 1'b0;
    end
    if (w.left_fall && !locked && !l_seen) begin
      l_stamp = tick;
      l_seen  = 1'b1;
      if (r_seen) locked = 1'b1;
    end
    if (w.right_fall && !locked && !r_seen) begin
      r_stamp = tick;
      r_seen  = 1'b1;
      if (l_seen) locked = 1'b1;
    end
    if (w.take && locked) begin
      d   = l_stamp - r_stamp;
      neg = d[31];
      mag = neg ? (33'h1_0000_0000 - {1'b0, d}) : {1'b0, d};
      l_seen = 1'b0;
      r_seen = 1'b0;
      locked = 1'b0;
      if (mag > {17'd0, full_scale}) mag = {17'd0, full_scale};
      if (mag <= {17'd0, dead_band}) begin
        r.status = STATUS_DEADZONE;
      end else begin
        muted     = 1'b1;
        mute_left = mute_len;
        // divisor is nonzero here: mag > dead_band >= 0 and mag <= full_scale
        q = ({15'd0, mag} * Q15_FULL) / {32'd0, full_scale};
        r.scaled_difference = neg ? -q[15:0] : q[15:0];
        r.status = STATUS_REPORTED;
      end
    end
    r.available = locked && !muted;
    tick = tick + 1'b1;
    return r;
  endfunction

  function automatic in_word_t word(input logic l, input logic r, input logic t);
    in_word_t w;
    w.left_fall  = l;
    w.right_fall = r;
    w.take       = t;
    return w;
  endfunction

  // Offer one word, with an optional idle burst first; valid stays high afterwards
  task automatic send_word(input in_word_t w);
    int gap;
    if (!idle_off && tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tick_results_q.push_back(predict_tick(w));
    words_sent++;
  endtask

  // Drop valid and wait until every expected word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAX_DIFF: full_scale = value[15:0];
      REG_DEADZONE: dead_band  = value[15:0];
      REG_SILENCE:  mute_len   = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] fs, input logic [15:0] db,
                           input logic [23:0] ml);
    settle();
    write_reg(REG_MAX_DIFF, {8'd0, fs});
    write_reg(REG_DEADZONE, {8'd0, db});
    write_reg(REG_SILENCE, ml);
  endtask

  // Random register setting, mostly small scales so clamping and rounding show up
  task automatic pick_setting();
    logic [15:0] fs;
    logic [15:0] db;
    logic [23:0] ml;
    case ($urandom_range(0, 4))
      0:       fs = 16'($urandom_range(1, 8));
      1, 2:    fs = 16'($urandom_range(9, 40));
      3:       fs = 16'($urandom_range(41, 65535));
      default: fs = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
    endcase
    case ($urandom_range(0, 5))
      0:       db = '0;
      1:       db = 16'($urandom_range(fs, 65535));
      default: db = 16'($urandom_range(0, fs / 3));
    endcase
    ml = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom_range(1, 40));
    echo_span = (fs > 40) ? 60 : int'(fs) + int'(fs) / 2 + 2;
    configure(fs, db, ml);
  endtask

  // One echo event: lead words, an edge on one side, spread words, an edge on the other side, late words, take
  task automatic play_echo(input int span);
    int       spread;
    int       lead;
    int       linger;
    bit       left_first;
    bit       fold_take;
    in_word_t w;
    lead       = $urandom_range(0, 2);
    spread     = $urandom_range(0, span);
    linger     = $urandom_range(0, 3);
    left_first = 1'($urandom_range(0, 1));
    fold_take  = ($urandom_range(0, 4) == 0);
    repeat (lead) send_word(word(1'b0, 1'b0, $urandom_range(0, 7) == 0));
    if (spread == 0) send_word(word(1'b1, 1'b1, 1'b0));
    else send_word(word(left_first, !left_first, 1'b0));
    if (spread != 0) begin
      // repeated edges on the side already stamped are ignored
      repeat (spread - 1) begin
        w = '0;
        if ($urandom_range(0, 3) == 0) begin
          w.left_fall  = left_first;
          w.right_fall = !left_first;
        end
        w.take = ($urandom_range(0, 7) == 0);
        send_word(w);
      end
      w = word(!left_first, left_first, fold_take);
      if ($urandom_range(0, 2) == 0) begin
        w.left_fall  = 1'b1;
        w.right_fall = 1'b1;
      end
      send_word(w);
    end
    if (!(fold_take && spread != 0)) begin
      // late edges while locked
      repeat (linger) send_word(word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'b0));
      send_word(word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1));
    end
  endtask

  task automatic random_traffic(input int until_count);
    int n;
    in_word_t w;
    while (words_sent < until_count) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          w = 3'($urandom_range(0, 7));
          send_word(w);
        end
      end else begin
        play_echo(echo_span);
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Take with nothing captured, straight out of reset
  task automatic test_empty_take();
    send_word(word(1'b0, 1'b0, 1'b1));
    send_word(word(1'b0, 1'b0, 1'b0));
  endtask

  // Reset registers: right after left, locked edges ignored, the pair taken, then a
  // left edge arriving with a take that finds no pair
  task automatic test_default_scale();
    send_word(word(1'b1, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b1, 1'b0));
    send_word(word(1'b1, 1'b1, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b1));
    send_word(word(1'b1, 1'b0, 1'b1));
  endtask

  // Widest and narrowest register values, zero full scale
  task automatic test_register_extremes();
    configure(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_word(word(1'b1, 1'b1, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b1));
    configure(16'd1, 16'd0, 24'hFFFFFF);
    send_word(word(1'b0, 1'b1, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b0));
    send_word(word(1'b1, 1'b0, 1'b1));
    send_word(word(1'b1, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b1, 1'b0));
    configure(16'd1, 16'd0, 24'd0);
    send_word(word(1'b0, 1'b0, 1'b1));
    send_word(word(1'b1, 1'b1, 1'b0));
    configure(16'd0, 16'd0, 24'd2);
    send_word(word(1'b0, 1'b0, 1'b1));
  endtask

  // Deadzone edge and a short silence running out
  task automatic test_silence_expiry();
    configure(16'd7, 16'd1, 24'd2);
    send_word(word(1'b1, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b1, 1'b1));
    send_word(word(1'b1, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b1, 1'b1));
    send_word(word(1'b1, 1'b1, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b0));
    send_word(word(1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random_echoes(input int until_count);
    int p;
    int chunk;
    chunk = (until_count - words_sent) / 8;
    for (p = 0; p < 8; p++) begin
      pick_setting();
      case ($urandom_range(0, 3))
        0:       tx_idle_odds = 0;
        1:       tx_idle_odds = 3;
        default: tx_idle_odds = $urandom_range(6, 20);
      endcase
      case ($urandom_range(0, 3))
        0:       rx_idle_odds = 0;
        1:       rx_idle_odds = 3;
        default: rx_idle_odds = $urandom_range(6, 20);
      endcase
      random_traffic((p == 7) ? until_count : words_sent + chunk);
    end
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    settle();
    tx_idle_odds = 0;
    hold_req = 1'b1;
    repeat (3) play_echo(6);
    settle();
    tx_idle_odds = 6;
  endtask

  // Sender waits for every outstanding word between events
  task automatic test_sender_pause();
    repeat (4) begin
      play_echo(echo_span);
      settle();
    end
  endtask

  // Last stretch with no idling on either side
  task automatic test_quiet_finish(input int until_count);
    idle_off = 1'b1;
    pick_setting();
    random_traffic(until_count);
  endtask

  // ---------------------------------------------------------------- processes

  // Receiver pacing: long hold on request, otherwise random stall bursts
  initial begin : rx_pacing
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!idle_off && rx_idle_odds != 0 &&
                   $urandom_range(1, rx_idle_odds) == 1) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = tick_results_q.pop_front();
        if (out_data.available !== want.available) begin
          $display("%0t: available mismatch, expected %0d, actual %0d",
                   $time, want.available, out_data.available);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.scaled_difference !== want.scaled_difference) begin
          $display("%0t: scaled_difference mismatch, expected %0d, actual %0d",
                   $time, want.scaled_difference, out_data.scaled_difference);
          errors++;
        end
      end
    end
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("dual_echo_arrival_difference regression: fail");
    $finish;
  end

  initial begin : main_seq
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_take();
    test_default_scale();
    test_register_extremes();
    test_silence_expiry();
    test_random_echoes(1450);
    test_backpressure();
    test_sender_pause();
    test_quiet_finish(1750);
    settle();
    if (errors == 0) begin
      $display("dual_echo_arrival_difference regression: pass");
    end else begin
      $display("dual_echo_arrival_difference regression: fail");
    end
    $finish;
  end

endmodule
